// ===== hdl/bip_pkg.sv =====
// ----------------------------------------------------------------------------
// bip_pkg
// Shared token codes, status codes, FSM states and the control/status bundles
// that pass between the infix-to-postfix controller and its datapath.
// ----------------------------------------------------------------------------
package bip_pkg;

  // Token and result kinds
  localparam logic [2:0] KIND_OPERAND = 3'd0;
  localparam logic [2:0] KIND_OR      = 3'd1;
  localparam logic [2:0] KIND_AND     = 3'd2;
  localparam logic [2:0] KIND_NOT     = 3'd3;
  localparam logic [2:0] KIND_OPEN    = 3'd4;
  localparam logic [2:0] KIND_CLOSE   = 3'd5;
  localparam logic [2:0] KIND_END     = 3'd6;

  // Result kind of the end status beat
  localparam logic [2:0] KIND_STATUS  = 3'd4;

  // Operator stack entry for an open paren (low two bits of KIND_OPEN)
  localparam logic [1:0] ENTRY_PAREN  = 2'd0;

  // End status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_PAREN   = 2'd1;
  localparam logic [1:0] STAT_OVF     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT_OPND,
    ST_OPEN_PUSH,
    ST_OP_POP,
    ST_CLOSE_POP,
    ST_FLUSH,
    ST_END_POP,
    ST_END_STAT
  } bip_state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // capture the accepted token
    logic push;       // push the token's stack code
    logic pop;        // drop the stack top
    logic to_pend;    // move stack top into the pending slot
    logic to_out;     // move stack top straight to the output, not last
    logic emit_opnd;  // send the operand beat
    logic emit_stat;  // send the end status beat, clear stack and error
    logic flush;      // send the pending operator as the last beat
    logic err_ovf;    // flag stack overflow
    logic err_paren;  // flag mismatched parens
  } bip_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic err_nz;
    logic cnt_zero;
    logic cnt_full;
    logic top_paren;
    logic top_pops;
    logic pend_valid;
    logic out_free;
  } bip_sts_t;

endpackage

// ===== hdl/bip_ram.sv =====
// ----------------------------------------------------------------------------
// bip_ram
// Generic single-write, single-read RAM with registered read data
// (read returns the old contents on a same-address write).
// ----------------------------------------------------------------------------
module bip_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bip_ctrl.sv =====
// ----------------------------------------------------------------------------
// bip_ctrl
// Sequencer for one token at a time: decode, pop loop, push, flush, status.
// ----------------------------------------------------------------------------
module bip_ctrl
  import bip_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_token_kind,
  output logic       in_stall,
  input  bip_sts_t   sts,
  output bip_cmd_t   cmd
);

  bip_state_t state_r, state_nxt;
  logic       pend_ok;

  // a pop into the pending slot may need to push the old pending beat out
  assign pend_ok = !sts.pend_valid || sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (in_token_kind == KIND_END) begin
            state_nxt = sts.err_nz ? ST_END_STAT : ST_END_POP;
          end else if (sts.err_nz) begin
            state_nxt = ST_IDLE;
          end else begin
            unique case (in_token_kind)
              KIND_OPERAND:                   state_nxt = ST_EMIT_OPND;
              KIND_OR, KIND_AND, KIND_NOT:    state_nxt = ST_OP_POP;
              KIND_OPEN:                      state_nxt = ST_OPEN_PUSH;
              KIND_CLOSE:                     state_nxt = ST_CLOSE_POP;
              default:                        state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_EMIT_OPND: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_OPEN_PUSH: state_nxt = ST_IDLE;
      ST_OP_POP: begin
        if (!(!sts.cnt_zero && sts.top_pops)) begin
          state_nxt = sts.pend_valid ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_CLOSE_POP: begin
        if (sts.cnt_zero || sts.top_paren) begin
          state_nxt = sts.pend_valid ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_END_POP: begin
        if (sts.cnt_zero || sts.top_paren) state_nxt = ST_END_STAT;
      end
      ST_END_STAT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      ST_EMIT_OPND: cmd.emit_opnd = sts.out_free;
      ST_OPEN_PUSH: begin
        if (sts.cnt_full) cmd.err_ovf = 1'b1;
        else              cmd.push    = 1'b1;
      end
      ST_OP_POP: begin
        if (!sts.cnt_zero && sts.top_pops) begin
          cmd.pop     = pend_ok;
          cmd.to_pend = pend_ok;
        end else if (sts.cnt_full) begin
          cmd.err_ovf = 1'b1;
        end else begin
          cmd.push = 1'b1;
        end
      end
      ST_CLOSE_POP: begin
        priority if (sts.cnt_zero) begin
          cmd.err_paren = 1'b1;
        end else if (sts.top_paren) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.pop     = pend_ok;
          cmd.to_pend = pend_ok;
        end
      end
      ST_FLUSH: cmd.flush = sts.out_free;
      ST_END_POP: begin
        priority if (sts.cnt_zero) begin
          cmd = '0;
        end else if (sts.top_paren) begin
          cmd.err_paren = 1'b1;
        end else begin
          cmd.pop    = sts.out_free;
          cmd.to_out = sts.out_free;
        end
      end
      ST_END_STAT: cmd.emit_stat = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !sts.pend_valid)
    else $error("pending operator left over in idle");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.cnt_full)
    else $error("push into a full stack");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !sts.cnt_zero)
    else $error("pop from an empty stack");

endmodule

// ===== hdl/bip_dp.sv =====
// ----------------------------------------------------------------------------
// bip_dp
// Token register, operator stack with count, sticky error, pending operator
// slot and the output register.
// ----------------------------------------------------------------------------
module bip_dp
  import bip_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] in_token_kind,
  input  logic [7:0] in_operand_id,
  input  bip_cmd_t   cmd,
  output bip_sts_t   sts,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_operand_id,
  output logic [1:0] out_status,
  output logic       out_last
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [2:0]    tok_kind_r;
  logic [7:0]    tok_id_r;
  logic [CW-1:0] count_r, count_nxt, count_dec;
  logic [1:0]    err_r, err_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [1:0]    pend_kind_r;
  logic          byp_valid_r;
  logic [1:0]    byp_val_r;
  logic [1:0]    ram_rdata, top;
  logic [2:0]    top_ext;
  logic          out_free, out_load;
  logic          out_valid_r;
  logic [2:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_id_r, out_id_nxt;
  logic [1:0]    out_stat_r, out_stat_nxt;
  logic          out_last_r, out_last_nxt;

  // stack: read address tracks the next top; a fresh push is bypassed
  assign count_dec = count_nxt - CW'(1);

  bip_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (count_r[AW-1:0]),
    .wdata (tok_kind_r[1:0]),
    .raddr (count_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign top     = byp_valid_r ? byp_val_r : ram_rdata;
  assign top_ext = {1'b0, top};

  always_comb begin
    count_nxt = count_r;
    if (cmd.emit_stat)  count_nxt = '0;
    else if (cmd.push)  count_nxt = count_r + CW'(1);
    else if (cmd.pop)   count_nxt = count_r - CW'(1);
  end

  always_comb begin
    err_nxt = err_r;
    if (cmd.emit_stat)                           err_nxt = STAT_OK;
    else if (cmd.err_ovf && err_r == STAT_OK)    err_nxt = STAT_OVF;
    else if (cmd.err_paren && err_r == STAT_OK)  err_nxt = STAT_PAREN;
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (cmd.to_pend)    pend_valid_nxt = 1'b1;
    else if (cmd.flush) pend_valid_nxt = 1'b0;
  end

  // output register
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = cmd.to_out || cmd.emit_opnd || cmd.emit_stat || cmd.flush ||
                    (cmd.to_pend && pend_valid_r);

  always_comb begin
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_stat_nxt = out_stat_r;
    out_last_nxt = out_last_r;
    priority if (cmd.emit_opnd) begin
      out_kind_nxt = KIND_OPERAND;
      out_id_nxt   = tok_id_r;
      out_stat_nxt = STAT_OK;
      out_last_nxt = 1'b1;
    end else if (cmd.emit_stat) begin
      out_kind_nxt = KIND_STATUS;
      out_id_nxt   = '0;
      out_stat_nxt = err_r;
      out_last_nxt = 1'b1;
    end else if (cmd.to_out) begin
      out_kind_nxt = top_ext;
      out_id_nxt   = '0;
      out_stat_nxt = STAT_OK;
      out_last_nxt = 1'b0;
    end else if (cmd.flush || (cmd.to_pend && pend_valid_r)) begin
      out_kind_nxt = {1'b0, pend_kind_r};
      out_id_nxt   = '0;
      out_stat_nxt = STAT_OK;
      out_last_nxt = cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      err_r        <= STAT_OK;
      pend_valid_r <= 1'b0;
      byp_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      err_r        <= err_nxt;
      pend_valid_r <= pend_valid_nxt;
      byp_valid_r  <= cmd.push;
      out_valid_r  <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tok_kind_r <= in_token_kind;
      tok_id_r   <= in_operand_id;
    end
    if (cmd.push)    byp_val_r   <= tok_kind_r[1:0];
    if (cmd.to_pend) pend_kind_r <= top;
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_id_r   <= out_id_nxt;
      out_stat_r <= out_stat_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // status to controller
  always_comb begin
    sts.err_nz     = (err_r != STAT_OK);
    sts.cnt_zero   = (count_r == '0);
    sts.cnt_full   = (count_r == CW'(STACK_DEPTH));
    sts.top_paren  = (top == ENTRY_PAREN);
    sts.top_pops   = (top != ENTRY_PAREN) &&
                     ((top_ext > tok_kind_r) ||
                      (top_ext == tok_kind_r && tok_kind_r != KIND_NOT));
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_operand_id = out_id_r;
  assign out_status     = out_stat_r;
  assign out_last       = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_OPERAND && out_kind_r != KIND_OR &&
     out_kind_r != KIND_AND && out_kind_r != KIND_NOT) |-> out_last_r)
    else $error("end status beat not marked last");

endmodule

// ===== hdl/boolean_infix_to_postfix.sv =====
// An operand or open paren token is latched in idle, then emitted or pushed;
//   an operator or a close paren pops operators off the stack into the pending
//   slot, then releases the final pending beat.
// The pop loop through the stack RAM read port moves one operator per cycle
//   while the output is free; a new token is taken only back in idle.
// End pops the stack out ahead of the status beat; on an error, status only.
// Reset (synchronous, rst_n low): stack empty, no error, no beat pending.
// ----------------------------------------------------------------------------
// boolean_infix_to_postfix
// Shunting-yard converter from infix boolean-query tokens to postfix beats,
// built as an FSM controller over a stack/output datapath.
// ----------------------------------------------------------------------------
module boolean_infix_to_postfix
  import bip_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  // token input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_token_kind,
  input  logic [7:0] in_operand_id,
  // postfix result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_operand_id,
  output logic [1:0] out_status,
  output logic       out_last
);

  bip_cmd_t cmd;
  bip_sts_t sts;

  // The controller takes one token per visit to idle. Operators pop into a
  // one-deep pending slot so the last popped beat can carry the last flag
  // once the loop knows it is done; end pops go straight out, since the
  // status beat always closes the group.
  bip_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_token_kind (in_token_kind),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  // Stack in a RAM with a registered read that always fetches the next top;
  // the output register holds a finished beat while the next work goes on.
  bip_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_token_kind  (in_token_kind),
    .in_operand_id  (in_operand_id),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_operand_id (out_operand_id),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule
